FILE: rtl/hrlp_pkg.sv
// hrlp_pkg: types, codes and name tables shared by the request line parser
// depends on nothing; imported by every module of the parser
`timescale 1ns / 1ps

package hrlp_pkg;

  localparam logic [6:0] URI_MAX    = 7'd64;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam int         N_METH     = 8;
  localparam int         N_PROTO    = 2;
  localparam logic [3:0] PROTO_LEN  = 4'd8;
  localparam logic [3:0] POS_MAX    = 4'd15;

  localparam logic       KIND_URI      = 1'b0;
  localparam logic       KIND_SUMMARY  = 1'b1;
  localparam logic [3:0] METH_UNKNOWN  = 4'd8;
  localparam logic [1:0] PROTO_UNKNOWN = 2'd2;

  typedef enum logic [1:0] {
    PH_METHOD,
    PH_URI,
    PH_PROTO,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       request_end;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] uri_byte;
    logic [5:0] uri_index;
    logic [3:0] method_code;
    logic [1:0] protocol_code;
    logic [6:0] uri_length;
    logic       uri_too_long;
    logic       bad_request;
  } res_t;

  function automatic logic [3:0] meth_len(input logic [2:0] idx);
    logic [3:0] len;
    unique case (idx)
      3'd0:    len = 4'd7;
      3'd1:    len = 4'd3;
      3'd2:    len = 4'd4;
      3'd3:    len = 4'd4;
      3'd4:    len = 4'd3;
      3'd5:    len = 4'd6;
      3'd6:    len = 4'd5;
      default: len = 4'd7;
    endcase
    return len;
  endfunction

  // names left-justified in 7 bytes, tail padded with zeros
  function automatic logic [7:0] meth_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [55:0] name;
    logic [55:0] shifted;
    unique case (idx)
      3'd0:    name = "OPTIONS";
      3'd1:    name = {"GET", 32'd0};
      3'd2:    name = {"HEAD", 24'd0};
      3'd3:    name = {"POST", 24'd0};
      3'd4:    name = {"PUT", 32'd0};
      3'd5:    name = {"DELETE", 8'd0};
      3'd6:    name = {"TRACE", 16'd0};
      default: name = "CONNECT";
    endcase
    shifted = name << {pos, 3'b000};
    return shifted[55:48];
  endfunction

  function automatic logic [7:0] proto_char(input logic idx, input logic [3:0] pos);
    logic [63:0] name;
    logic [63:0] shifted;
    name    = idx ? "HTTP/1.1" : "HTTP/1.0";
    shifted = name << {pos, 3'b000};
    return shifted[63:56];
  endfunction

endpackage

FILE: rtl/hrlp_parse.sv
// hrlp_parse: request line state and the combinational step for one request byte
// depends on hrlp_pkg
`timescale 1ns / 1ps

module hrlp_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  hrlp_pkg::req_t item,
  output logic          push,
  output hrlp_pkg::res_t result
);
  import hrlp_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] mcand, mcand_next;
  logic [3:0] mpos, mpos_next;
  logic [6:0] ucnt, ucnt_next;
  logic       tl, tl_next;
  logic [1:0] pcand, pcand_next;
  logic [3:0] ppos, ppos_next;

  logic       eol;
  logic       is_space;
  logic       uri_full;
  logic       tl_eff;
  logic       uri_out;
  logic [3:0] mc;
  logic [1:0] pc;

  assign eol      = (item.byte_in == CH_CR) || (item.byte_in == CH_LF);
  assign is_space = (item.byte_in == CH_SPACE);
  assign uri_full = (ucnt >= URI_MAX);

  // next state
  always_comb begin
    phase_next = phase;
    mcand_next = mcand;
    mpos_next  = mpos;
    ucnt_next  = ucnt;
    tl_next    = tl;
    pcand_next = pcand;
    ppos_next  = ppos;
    if (item.request_end) begin
      phase_next = PH_METHOD;
      mcand_next = '1;
      mpos_next  = '0;
      ucnt_next  = '0;
      tl_next    = 1'b0;
      pcand_next = '1;
      ppos_next  = '0;
    end else begin
      unique case (phase)
        PH_METHOD: begin
          if (eol) begin
            phase_next = PH_DONE;
          end else if (is_space) begin
            phase_next = PH_URI;
          end else begin
            for (int i = 0; i < N_METH; i++) begin
              mcand_next[i] = mcand[i] && (mpos < meth_len(3'(i)))
                              && (meth_char(3'(i), mpos) == item.byte_in);
            end
            if (mpos != POS_MAX) mpos_next = mpos + 4'd1;
          end
        end
        PH_URI: begin
          if (eol) begin
            if (uri_full) tl_next = 1'b1;
            phase_next = PH_DONE;
          end else if (is_space) begin
            phase_next = PH_PROTO;
          end else if (!uri_full) begin
            ucnt_next = ucnt + 7'd1;
          end else begin
            tl_next = 1'b1;
          end
        end
        PH_PROTO: begin
          if (eol) begin
            phase_next = PH_DONE;
          end else begin
            for (int i = 0; i < N_PROTO; i++) begin
              pcand_next[i] = pcand[i] && (ppos < PROTO_LEN)
                              && (proto_char(1'(i), ppos) == item.byte_in);
            end
            if (ppos != POS_MAX) ppos_next = ppos + 4'd1;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  // summary fields, lowest matching table entry wins
  always_comb begin
    mc = METH_UNKNOWN;
    for (int i = N_METH - 1; i >= 0; i--) begin
      if (mcand[i] && (mpos == meth_len(3'(i)))) mc = {1'b0, 3'(i)};
    end
    pc = PROTO_UNKNOWN;
    if (ppos == PROTO_LEN) begin
      if (pcand[1]) pc = 2'd1;
      if (pcand[0]) pc = 2'd0;
    end
  end

  assign tl_eff  = tl || ((phase == PH_URI) && uri_full);
  assign uri_out = !item.request_end && (phase == PH_URI) && !eol && !is_space && !uri_full;

  // outputs
  always_comb begin
    result = '0;
    if (item.request_end) begin
      push = step && (phase != PH_DONE);
    end else begin
      push = step && (uri_out || (eol && (phase != PH_DONE)));
    end
    if (uri_out) begin
      result.kind      = KIND_URI;
      result.uri_byte  = item.byte_in;
      result.uri_index = ucnt[5:0];
    end else begin
      result.kind          = KIND_SUMMARY;
      result.method_code   = mc;
      result.protocol_code = pc;
      result.uri_length    = ucnt;
      result.uri_too_long  = tl_eff;
      result.bad_request   = (mc == METH_UNKNOWN) || (pc == PROTO_UNKNOWN) || tl_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_METHOD;
      mcand <= '1;
      mpos  <= '0;
      ucnt  <= '0;
      tl    <= 1'b0;
      pcand <= '1;
      ppos  <= '0;
    end else if (step) begin
      phase <= phase_next;
      mcand <= mcand_next;
      mpos  <= mpos_next;
      ucnt  <= ucnt_next;
      tl    <= tl_next;
      pcand <= pcand_next;
      ppos  <= ppos_next;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    step && item.request_end |=> (phase == PH_METHOD) && (ucnt == 7'd0) && (mpos == 4'd0))
    else $error("request end did not return parser to method field");

  a_uri_bound: assert property (@(posedge clk) disable iff (rst)
    push && (result.kind == KIND_URI) |-> (ucnt < URI_MAX) && (phase == PH_URI))
    else $error("uri byte emitted beyond uri limit");

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    step && (phase == PH_DONE) && !item.request_end |-> !push)
    else $error("result emitted after the request line was finished");

endmodule

FILE: rtl/hrlp_out_queue.sv
// hrlp_out_queue: two-entry result queue between the parser and the result port
// depends on hrlp_pkg
`timescale 1ns / 1ps

module hrlp_out_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hrlp_pkg::res_t din,
  output logic           space,
  output logic           valid,
  input  logic           stall,
  output hrlp_pkg::res_t dout
);
  import hrlp_pkg::*;

  res_t       slot0;
  res_t       slot1;
  logic [1:0] cnt, cnt_next;
  logic       pop;

  // space depends on occupancy only, so no path from the result stall to input
  assign space = (cnt != 2'd2);
  assign valid = (cnt != 2'd0);
  assign dout  = slot0;
  assign pop   = valid && !stall;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) cnt_next = cnt + 2'd1;
    else if (pop && !push) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (cnt == 2'd1)) slot0 <= din;
      else slot0 <= slot1;
      if (push && (cnt == 2'd2)) slot1 <= din;
    end else if (push) begin
      if (cnt == 2'd0) slot0 <= din;
      else slot1 <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> space || pop)
    else $error("result pushed into a full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> cnt != 2'd3)
    else $error("queue occupancy out of range");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> cnt == $past(cnt) + 2'd1)
    else $error("queue occupancy lost a push");

endmodule

FILE: rtl/http_request_line_parser.sv
// Takes one request byte per cycle on the req channel and returns uri bytes and one
// summary per request line on the res channel. A request is accepted every cycle while
// the two-entry result queue has room; it is held in the input register, parsed against
// the method and protocol name tables once the queue has room, and any result goes through
// the queue to res. Stalls on res back up through the queue and the input register.
// depends on hrlp_pkg, hrlp_parse, hrlp_out_queue
`timescale 1ns / 1ps

module http_request_line_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  hrlp_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_stall,
  output hrlp_pkg::res_t res
);
  import hrlp_pkg::*;

  logic v1;
  req_t item1;
  logic space;
  logic step;
  logic push;
  res_t result;

  assign step      = v1 && space;
  assign req_stall = v1 && !space;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!req_stall) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) item1 <= req;
  end

  hrlp_parse u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item1),
    .push   (push),
    .result (result)
  );

  hrlp_out_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (result),
    .space (space),
    .valid (res_valid),
    .stall (res_stall),
    .dout  (res)
  );

endmodule

FILE: tb/sv/tb_http_request_line_parser.sv
// tb_http_request_line_parser: self-checking bench for the request line parser
// drives request bytes over the valid/stall channel and checks every uri byte and summary
// depends on hrlp_pkg and http_request_line_parser
`timescale 1ns / 1ps

module tb_http_request_line_parser;
  import hrlp_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 160;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic res_valid;
  logic res_stall;
  res_t res;

  http_request_line_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // parser state mirrored on the bench side
  phase_t     line_phase;
  logic [7:0] meth_live;
  logic [3:0] meth_pos;
  logic [6:0] uri_count;
  logic       uri_overflow;
  logic [1:0] proto_live;
  logic [3:0] proto_pos;

  res_t pending_results[$];
  int   failures;
  int   bytes_sent;
  int   cycle_count;
  bit   sender_idle_en;
  bit   receiver_stall_en;
  bit   hold_pending;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic string method_name(input int idx);
    string s;
    case (idx)
      0:       s = "OPTIONS";
      1:       s = "GET";
      2:       s = "HEAD";
      3:       s = "POST";
      4:       s = "PUT";
      5:       s = "DELETE";
      6:       s = "TRACE";
      default: s = "CONNECT";
    endcase
    return s;
  endfunction

  function automatic string proto_name(input int idx);
    string s;
    if (idx == 1) begin
      s = "HTTP/1.1";
    end else begin
      s = "HTTP/1.0";
    end
    return s;
  endfunction

  function automatic void clear_line_state();
    line_phase   = PH_METHOD;
    meth_live    = '1;
    meth_pos     = '0;
    uri_count    = '0;
    uri_overflow = 1'b0;
    proto_live   = '1;
    proto_pos    = '0;
  endfunction

  function automatic void push_line_summary();
    res_t s;
    int   i;
    s               = '0;
    s.kind          = KIND_SUMMARY;
    s.method_code   = METH_UNKNOWN;
    s.protocol_code = PROTO_UNKNOWN;
    // scan downwards so the lowest matching code wins
    for (i = N_METH - 1; i >= 0; i--) begin
      if (meth_live[i] && meth_pos == method_name(i).len()) s.method_code = i[3:0];
    end
    for (i = N_PROTO - 1; i >= 0; i--) begin
      if (proto_live[i] && proto_pos == PROTO_LEN) s.protocol_code = i[1:0];
    end
    s.uri_length   = uri_count;
    s.uri_too_long = uri_overflow;
    s.bad_request  = (s.method_code == METH_UNKNOWN) || (s.protocol_code == PROTO_UNKNOWN) ||
                     uri_overflow;
    pending_results.push_back(s);
  endfunction

  function automatic void parse_byte(input req_t r);
    logic [7:0] b;
    logic       eol;
    res_t       u;
    string      nm;
    int         i;
    b   = r.byte_in;
    eol = (b == CH_CR) || (b == CH_LF);
    if (r.request_end) begin
      if (line_phase == PH_URI && uri_count >= URI_MAX) uri_overflow = 1'b1;
      if (line_phase != PH_DONE) push_line_summary();
      clear_line_state();
    end else begin
      case (line_phase)
        PH_METHOD: begin
          if (eol) begin
            push_line_summary();
            line_phase = PH_DONE;
          end else if (b == CH_SPACE) begin
            line_phase = PH_URI;
          end else begin
            for (i = 0; i < N_METH; i++) begin
              nm = method_name(i);
              if (meth_pos >= nm.len() || nm.getc(meth_pos) != b) meth_live[i] = 1'b0;
            end
            if (meth_pos != POS_MAX) meth_pos++;
          end
        end
        PH_URI: begin
          if (eol) begin
            if (uri_count >= URI_MAX) uri_overflow = 1'b1;
            push_line_summary();
            line_phase = PH_DONE;
          end else if (b == CH_SPACE) begin
            line_phase = PH_PROTO;
          end else if (uri_count < URI_MAX) begin
            u           = '0;
            u.kind      = KIND_URI;
            u.uri_byte  = b;
            u.uri_index = uri_count[5:0];
            pending_results.push_back(u);
            uri_count++;
          end else begin
            uri_overflow = 1'b1;
          end
        end
        PH_PROTO: begin
          if (eol) begin
            push_line_summary();
            line_phase = PH_DONE;
          end else begin
            // spaces are part of the protocol text here
            for (i = 0; i < N_PROTO; i++) begin
              nm = proto_name(i);
              if (proto_pos >= PROTO_LEN || nm.getc(proto_pos) != b) proto_live[i] = 1'b0;
            end
            if (proto_pos != POS_MAX) proto_pos++;
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void check_result(input res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected result: kind=%0d byte=%02h idx=%0d meth=%0d proto=%0d len=%0d",
                 got.kind, got.uri_byte, got.uri_index, got.method_code, got.protocol_code,
                 got.uri_length);
    end else begin
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.uri_byte !== want.uri_byte ||
          got.uri_index !== want.uri_index || got.method_code !== want.method_code ||
          got.protocol_code !== want.protocol_code || got.uri_length !== want.uri_length ||
          got.uri_too_long !== want.uri_too_long || got.bad_request !== want.bad_request) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch at %0t: kind byte idx meth proto len long bad", $realtime);
          $display("  exp %0d %02h %0d %0d %0d %0d %0d %0d",
                   want.kind, want.uri_byte, want.uri_index, want.method_code,
                   want.protocol_code, want.uri_length, want.uri_too_long, want.bad_request);
          $display("  got %0d %02h %0d %0d %0d %0d %0d %0d",
                   got.kind, got.uri_byte, got.uri_index, got.method_code,
                   got.protocol_code, got.uri_length, got.uri_too_long, got.bad_request);
        end
      end
    end
  endfunction

  // both channels are sampled at the edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) parse_byte(req);
      if (res_valid && !res_stall) check_result(res);
    end
  end

  // receiver side: random stall bursts, plus one long hold-off on demand
  initial begin
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
        hold_pending = 1'b0;
      end else if (receiver_stall_en && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  task automatic send_req(input logic [7:0] b, input logic last);
    if (sender_idle_en && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{byte_in: b, request_end: last};
    do @(posedge clk); while (req_stall);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_req(b, 1'b0);
  endtask

  task automatic send_end();
    send_req(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s.getc(i));
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_uri_run(input int n);
    int i;
    for (i = 0; i < n; i++) send_byte(8'(8'h61 + (i % 26)));
  endtask

  task automatic send_line(input string meth, input string uri, input string proto);
    send_text(meth);
    send_byte(CH_SPACE);
    send_text(uri);
    send_byte(CH_SPACE);
    send_text(proto);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_text_byte(input bit allow_space);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_CR || c == CH_LF || (!allow_space && c == CH_SPACE))
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] random_uri_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) != 0) begin
      c = 8'($urandom_range(8'h21, 8'h7E));
    end else begin
      c = random_text_byte(1'b0);
    end
    return c;
  endfunction

  task automatic send_random_method();
    string nm;
    int    mode;
    int    i;
    int    k;
    nm   = method_name($urandom_range(0, 7));
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      send_text(nm);
    end else if (mode == 7) begin
      k = $urandom_range(0, nm.len() - 1);
      for (i = 0; i < nm.len(); i++) begin
        if (i == k) send_byte(random_text_byte(1'b0));
        else send_byte(nm.getc(i));
      end
    end else if (mode == 8) begin
      k = $urandom_range(0, nm.len());
      for (i = 0; i < k; i++) send_byte(nm.getc(i));
      if (k == nm.len()) send_byte(random_text_byte(1'b0));
    end else begin
      repeat ($urandom_range(1, 9)) send_byte(random_text_byte(1'b0));
    end
  endtask

  task automatic send_random_protocol();
    string nm;
    int    mode;
    int    i;
    int    k;
    nm   = proto_name($urandom_range(0, 1));
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      send_text(nm);
    end else if (mode == 7) begin
      k = $urandom_range(0, 7);
      for (i = 0; i < k; i++) send_byte(nm.getc(i));
    end else if (mode == 8) begin
      send_text(nm);
      send_byte(random_text_byte(1'b1));
    end else begin
      k = $urandom_range(0, 7);
      for (i = 0; i < 8; i++) begin
        if (i == k) send_byte(random_text_byte(1'b1));
        else send_byte(nm.getc(i));
      end
    end
  endtask

  task automatic send_random_request();
    int r;
    int n;
    if ($urandom_range(0, 19) == 0) begin
      // raw noise
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_random_method();
      if ($urandom_range(0, 24) != 0) begin
        send_byte(CH_SPACE);
        r = $urandom_range(0, 9);
        n = (r < 7) ? $urandom_range(0, 12) : (r < 9) ? $urandom_range(13, 50) :
            $urandom_range(60, 72);
        repeat (n) send_byte(random_uri_char());
        if ($urandom_range(0, 19) != 0) begin
          send_byte(CH_SPACE);
          send_random_protocol();
        end
      end
      r = $urandom_range(0, 9);
      if (r < 5) send_crlf();
      else if (r < 7) send_byte(CH_LF);
      else if (r == 7) send_byte(CH_CR);
      // trailing lines are ignored by the block
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end
    send_end();
  endtask

  task automatic test_directed();
    sender_idle_en    = 1'b1;
    receiver_stall_en = 1'b1;
    send_line("GET", "/index.html", "HTTP/1.1");
    send_crlf();
    send_text("Host: a");
    send_crlf();
    send_end();
    send_line("OPTIONS", "*", "HTTP/1.0");
    send_byte(CH_LF);
    send_end();
    send_line("HEAD", "/h", "HTTP/1.1");
    send_byte(CH_CR);
    send_end();
    send_line("POST", "/p", "HTTP/1.0");
    send_crlf();
    send_end();
    send_line("PUT", "/u", "HTTP/1.1");
    send_end();
    send_line("DELETE", "/d", "HTTP/1.0");
    send_byte(CH_LF);
    send_end();
    send_line("TRACE", "/t", "HTTP/1.1");
    send_byte(CH_LF);
    send_end();
    send_line("CONNECT", "h:1", "HTTP/1.1");
    send_byte(CH_LF);
    send_end();
    // empty request
    send_end();
    // line ends in the method, in the uri, with an empty protocol, and with an empty uri
    send_text("GET");
    send_byte(CH_CR);
    send_end();
    send_text("GET /a");
    send_byte(CH_LF);
    send_end();
    send_text("GET /a ");
    send_byte(CH_CR);
    send_end();
    send_text("GET  HTTP/1.1");
    send_byte(CH_LF);
    send_end();
    // uri at the limit, and over it
    send_text("GET ");
    send_uri_run(64);
    send_text(" HTTP/1.0");
    send_byte(CH_LF);
    send_end();
    send_text("GET ");
    send_uri_run(64);
    send_byte(CH_CR);
    send_end();
    send_text("GET ");
    send_uri_run(70);
    send_text(" HTTP/1.1");
    send_byte(CH_LF);
    send_end();
    send_text("GET ");
    send_uri_run(64);
    send_end();
    // unknown methods and protocols
    send_line("get", "/", "HTTP/1.1");
    send_byte(CH_LF);
    send_end();
    send_line("GETS", "/", "HTTP/1.0");
    send_byte(CH_LF);
    send_end();
    send_line("PUT", "/x", "HTTP/1.2");
    send_byte(CH_LF);
    send_end();
    send_line("PUT", "/x", "HTTP/1.1 ");
    send_byte(CH_LF);
    send_end();
    send_line("PUT", "/x", "HTTP/1.10");
    send_byte(CH_LF);
    send_end();
    // byte extremes in the method and the uri
    send_byte(8'hFF);
    send_byte(CH_SPACE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_text(" HTTP/1.0");
    send_crlf();
    send_end();
    send_text("POS");
    send_end();
    drain_results();
  endtask

  task automatic test_random_requests(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      // some requests run with no idling on either side
      sender_idle_en    = ($urandom_range(0, 3) != 0);
      receiver_stall_en = ($urandom_range(0, 3) != 0);
      send_random_request();
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    sender_idle_en    = 1'b0;
    receiver_stall_en = 1'b0;
    hold_pending      = 1'b1;
    send_text("POST /");
    repeat (60) send_byte(random_uri_char());
    send_text(" HTTP/1.1");
    send_crlf();
    send_end();
    drain_results();
  endtask

  task automatic test_final_burst(input int n_bytes);
    int target;
    sender_idle_en    = 1'b0;
    receiver_stall_en = 1'b0;
    target            = bytes_sent + n_bytes;
    while (bytes_sent < target) send_random_request();
    drain_results();
  endtask

  initial begin
    rst               = 1'b1;
    req_valid         = 1'b0;
    req               = '0;
    failures          = 0;
    bytes_sent        = 0;
    cycle_count       = 0;
    sender_idle_en    = 1'b0;
    receiver_stall_en = 1'b0;
    hold_pending      = 1'b0;
    clear_line_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_requests(750);
    test_backpressure();
    test_final_burst(500);

    if (failures == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
